// ----- src/ksrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyframe repetition counter package
// Shared constants, register indexes, item and control types, and the
// ternary feature compare used by the keyframe matcher.
// ----------------------------------------------------------------------------
package ksrc_pkg;

   localparam int MAX_FRAMES    = 16;
   localparam int FEATURE_COUNT = 17;
   localparam int CODE_BITS     = 2;

   localparam int PATTERN_W = FEATURE_COUNT * CODE_BITS;
   localparam int INDEX_W   = $clog2(MAX_FRAMES);
   localparam int FRAMES_W  = $clog2(MAX_FRAMES + 1);
   localparam int COUNT_W   = 16;
   localparam int FUNC_W    = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_SEL_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Item function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_FULL  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_IDEAL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POSE       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET_ACTIVE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd5;

   // Register indexes (word address)
   localparam logic [REG_SEL_W-1:0] REG_REP_LIMIT     = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_SECOND_LIMIT  = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_FRAMES_IN_USE = 2'd2;

   localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(1);

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [INDEX_W-1:0]       frame_slot;
      logic [PATTERN_W-1:0]     pattern_codes;
      logic [FEATURE_COUNT-1:0] care_bits;
      logic [PATTERN_W-1:0]     pose_codes;
      logic                     run_enable;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] reps_done;
      logic [COUNT_W-1:0] seconds_done;
      logic               last_rep_perfect;
      logic [INDEX_W-1:0] frame_position;
      logic               rep_event;
      logic               tick_event;
      logic               end_event;
      logic               finished;
   } rsp_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  rep_limit;
      logic [COUNT_W-1:0]  second_limit;
      logic [FRAMES_W-1:0] frames_in_use;
   } cfg_type;

   typedef struct packed {
      logic [PATTERN_W-1:0]     codes;
      logic [FEATURE_COUNT-1:0] care;
   } keyframe_type;

   typedef struct packed {
      logic               full_we;
      logic               ideal_we;
      logic [INDEX_W-1:0] slot;
      keyframe_type       frame;
   } store_wr_type;

   // A feature whose care bit is clear always matches.
   function automatic logic ternary_match(input logic [PATTERN_W-1:0]     codes,
                                          input logic [FEATURE_COUNT-1:0] care,
                                          input logic [PATTERN_W-1:0]     pose);
      logic hit;
      hit = 1'b1;
      for (int i = 0; i < FEATURE_COUNT; i++) begin
         if (care[i] && (codes[i*CODE_BITS +: CODE_BITS] != pose[i*CODE_BITS +: CODE_BITS])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

endpackage

// ----- src/ksrc_if.sv -----
// ----------------------------------------------------------------------------
// Keyframe repetition counter channels
// Valid/ready interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
interface ksrc_req_if;
   logic                               valid;
   logic                               ready;
   logic [ksrc_pkg::FUNC_W-1:0]        func;
   logic [ksrc_pkg::INDEX_W-1:0]       frame_slot;
   logic [ksrc_pkg::PATTERN_W-1:0]     pattern_codes;
   logic [ksrc_pkg::FEATURE_COUNT-1:0] care_bits;
   logic [ksrc_pkg::PATTERN_W-1:0]     pose_codes;
   logic                               run_enable;

   modport source (output valid, func, frame_slot, pattern_codes, care_bits, pose_codes,
                   run_enable, input ready);
   modport sink   (input valid, func, frame_slot, pattern_codes, care_bits, pose_codes,
                   run_enable, output ready);
endinterface

interface ksrc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ksrc_pkg::COUNT_W-1:0] reps_done;
   logic [ksrc_pkg::COUNT_W-1:0] seconds_done;
   logic                         last_rep_perfect;
   logic [ksrc_pkg::INDEX_W-1:0] frame_position;
   logic                         rep_event;
   logic                         tick_event;
   logic                         end_event;
   logic                         finished;

   modport source (output valid, reps_done, seconds_done, last_rep_perfect, frame_position,
                   rep_event, tick_event, end_event, finished, input ready);
   modport sink   (input valid, reps_done, seconds_done, last_rep_perfect, frame_position,
                   rep_event, tick_event, end_event, finished, output ready);
endinterface

// ----- src/ksrc_csr.sv -----
// ----------------------------------------------------------------------------
// Keyframe repetition counter registers
// APB-style register bank holding the limits and the keyframe count.
// ----------------------------------------------------------------------------
module ksrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ksrc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ksrc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ksrc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output ksrc_pkg::cfg_type                   cfg
);

   logic [ksrc_pkg::COUNT_W-1:0]   rep_limit_ff;
   logic [ksrc_pkg::COUNT_W-1:0]   second_limit_ff;
   logic [ksrc_pkg::FRAMES_W-1:0]  frames_ff;
   logic [ksrc_pkg::REG_SEL_W-1:0] reg_sel;
   logic                           wr_en;

   assign reg_sel    = csr_paddr[ksrc_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_limit_ff    <= '0;
         second_limit_ff <= '0;
         frames_ff       <= ksrc_pkg::FRAMES_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            ksrc_pkg::REG_REP_LIMIT: begin
               rep_limit_ff <= csr_pwdata[ksrc_pkg::COUNT_W-1:0];
            end
            ksrc_pkg::REG_SECOND_LIMIT: begin
               second_limit_ff <= csr_pwdata[ksrc_pkg::COUNT_W-1:0];
            end
            ksrc_pkg::REG_FRAMES_IN_USE: begin
               frames_ff <= csr_pwdata[ksrc_pkg::FRAMES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ksrc_pkg::REG_REP_LIMIT:     csr_prdata = ksrc_pkg::CSR_DATA_W'(rep_limit_ff);
         ksrc_pkg::REG_SECOND_LIMIT:  csr_prdata = ksrc_pkg::CSR_DATA_W'(second_limit_ff);
         ksrc_pkg::REG_FRAMES_IN_USE: csr_prdata = ksrc_pkg::CSR_DATA_W'(frames_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.rep_limit     = rep_limit_ff;
   assign cfg.second_limit  = second_limit_ff;
   assign cfg.frames_in_use = frames_ff;

endmodule

// ----- src/ksrc_store.sv -----
// ----------------------------------------------------------------------------
// Keyframe store
// Complete and perfect keyframe tables, one write port and one read
// port per table.
// ----------------------------------------------------------------------------
module ksrc_store (
   input  logic                          clock,
   input  ksrc_pkg::store_wr_type        wr,
   input  logic [ksrc_pkg::INDEX_W-1:0]  full_addr,
   input  logic [ksrc_pkg::INDEX_W-1:0]  ideal_addr,
   output ksrc_pkg::keyframe_type        full_rd,
   output ksrc_pkg::keyframe_type        ideal_rd
);

   // Contents are undefined until a slot is loaded, so no reset is applied.
   ksrc_pkg::keyframe_type full_ff  [ksrc_pkg::MAX_FRAMES];
   ksrc_pkg::keyframe_type ideal_ff [ksrc_pkg::MAX_FRAMES];

   always_ff @(posedge clock) begin
      if (wr.full_we) begin
         full_ff[wr.slot] <= wr.frame;
      end
      if (wr.ideal_we) begin
         ideal_ff[wr.slot] <= wr.frame;
      end
   end

   assign full_rd  = full_ff[full_addr];
   assign ideal_rd = ideal_ff[ideal_addr];

endmodule

// ----- src/ksrc_core.sv -----
// ----------------------------------------------------------------------------
// Keyframe repetition counter core
// Input register, keyframe matching and counter update, result register.
// ----------------------------------------------------------------------------
module ksrc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  ksrc_pkg::req_item_type        req_item,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output ksrc_pkg::rsp_item_type        rsp_item,
   input  logic                          rsp_ready,
   input  ksrc_pkg::cfg_type             cfg,
   output ksrc_pkg::store_wr_type        store_wr,
   output logic [ksrc_pkg::INDEX_W-1:0]  full_addr,
   output logic [ksrc_pkg::INDEX_W-1:0]  ideal_addr,
   input  ksrc_pkg::keyframe_type        full_rd,
   input  ksrc_pkg::keyframe_type        ideal_rd
);

   logic                          in_valid_ff;
   ksrc_pkg::req_item_type        in_item_ff;
   logic                          out_valid_ff;
   ksrc_pkg::rsp_item_type        out_item_ff;
   ksrc_pkg::rsp_item_type        out_item_in;
   logic                          advance;

   logic [ksrc_pkg::INDEX_W-1:0]  full_idx_ff,  full_idx_in;
   logic [ksrc_pkg::INDEX_W-1:0]  ideal_idx_ff, ideal_idx_in;
   logic [ksrc_pkg::COUNT_W-1:0]  rep_ff,       rep_in;
   logic [ksrc_pkg::COUNT_W-1:0]  sec_ff,       sec_in;
   logic                          perfect_ff,   perfect_in;
   logic                          running_ff,   running_in;
   logic                          ended_ff,     ended_in;

   logic [ksrc_pkg::FRAMES_W-1:0] frames;
   logic [ksrc_pkg::FRAMES_W-1:0] full_step;
   logic [ksrc_pkg::FRAMES_W-1:0] ideal_cur;
   logic [ksrc_pkg::FRAMES_W-1:0] ideal_step;
   logic [ksrc_pkg::FRAMES_W-1:0] ideal_after;
   logic                          full_hit;
   logic                          ideal_hit;
   logic                          slot_ok;
   logic                          rep_ev, tick_ev, end_ev;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // A keyframe count of zero acts as one, and anything above the table depth
   // is clamped to it.
   always_comb begin
      if (cfg.frames_in_use == '0) begin
         frames = ksrc_pkg::FRAMES_W'(1);
      end else if (cfg.frames_in_use > ksrc_pkg::FRAMES_W'(ksrc_pkg::MAX_FRAMES)) begin
         frames = ksrc_pkg::FRAMES_W'(ksrc_pkg::MAX_FRAMES);
      end else begin
         frames = cfg.frames_in_use;
      end
   end

   assign full_addr  = full_idx_ff;
   assign ideal_addr = ideal_idx_ff;
   assign full_hit   = ksrc_pkg::ternary_match(full_rd.codes, full_rd.care,
                                               in_item_ff.pose_codes);
   assign ideal_hit  = ksrc_pkg::ternary_match(ideal_rd.codes, ideal_rd.care,
                                               in_item_ff.pose_codes);
   assign full_step  = {1'b0, full_idx_ff} + ksrc_pkg::FRAMES_W'(1);
   assign ideal_cur  = {1'b0, ideal_idx_ff};
   assign ideal_step = ideal_cur + ksrc_pkg::FRAMES_W'(1);
   assign slot_ok    = ksrc_pkg::FRAMES_W'(in_item_ff.frame_slot)
                       < ksrc_pkg::FRAMES_W'(ksrc_pkg::MAX_FRAMES);

   always_comb begin
      full_idx_in          = full_idx_ff;
      ideal_idx_in         = ideal_idx_ff;
      rep_in               = rep_ff;
      sec_in               = sec_ff;
      perfect_in           = perfect_ff;
      running_in           = running_ff;
      ended_in             = ended_ff;
      ideal_after          = ideal_cur;
      rep_ev               = 1'b0;
      tick_ev              = 1'b0;
      end_ev               = 1'b0;
      store_wr.full_we     = 1'b0;
      store_wr.ideal_we    = 1'b0;
      store_wr.slot        = in_item_ff.frame_slot;
      store_wr.frame.codes = in_item_ff.pattern_codes;
      store_wr.frame.care  = in_item_ff.care_bits;
      unique case (in_item_ff.func)
         ksrc_pkg::FUNC_LOAD_FULL: begin
            store_wr.full_we = advance && slot_ok;
         end
         ksrc_pkg::FUNC_LOAD_IDEAL: begin
            store_wr.ideal_we = advance && slot_ok;
         end
         ksrc_pkg::FUNC_POSE: begin
            if (full_hit) begin
               if ((ideal_cur < frames) && ideal_hit) begin
                  ideal_after = ideal_step;
               end
               if (full_step >= frames) begin
                  if (rep_ff != ksrc_pkg::COUNT_MAX) begin
                     rep_in = rep_ff + ksrc_pkg::COUNT_W'(1);
                  end
                  perfect_in = (ideal_after >= frames);
                  rep_ev     = 1'b1;
                  if ((cfg.rep_limit != '0) && (rep_in >= cfg.rep_limit)) begin
                     ended_in = 1'b1;
                     end_ev   = 1'b1;
                  end
                  full_idx_in  = '0;
                  ideal_idx_in = '0;
               end else begin
                  full_idx_in  = full_step[ksrc_pkg::INDEX_W-1:0];
                  ideal_idx_in = ideal_after[ksrc_pkg::INDEX_W-1:0];
               end
            end
         end
         ksrc_pkg::FUNC_TICK: begin
            if (running_ff && !ended_ff) begin
               if (sec_ff != ksrc_pkg::COUNT_MAX) begin
                  sec_in = sec_ff + ksrc_pkg::COUNT_W'(1);
               end
               tick_ev = 1'b1;
               if ((cfg.second_limit != '0) && (sec_in >= cfg.second_limit)) begin
                  ended_in = 1'b1;
                  end_ev   = 1'b1;
               end
            end
         end
         ksrc_pkg::FUNC_SET_ACTIVE: begin
            running_in = in_item_ff.run_enable;
         end
         ksrc_pkg::FUNC_STOP: begin
            ended_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_item_in.reps_done        = rep_in;
      out_item_in.seconds_done     = sec_in;
      out_item_in.last_rep_perfect = perfect_in;
      out_item_in.frame_position   = full_idx_in;
      out_item_in.rep_event        = rep_ev;
      out_item_in.tick_event       = tick_ev;
      out_item_in.end_event        = end_ev;
      out_item_in.finished         = ended_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_idx_ff  <= '0;
         ideal_idx_ff <= '0;
         rep_ff       <= '0;
         sec_ff       <= '0;
         perfect_ff   <= 1'b0;
         running_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            full_idx_ff  <= full_idx_in;
            ideal_idx_ff <= ideal_idx_in;
            rep_ff       <= rep_in;
            sec_ff       <= sec_in;
            perfect_ff   <= perfect_in;
            running_ff   <= running_in;
            ended_ff     <= ended_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ----- src/keyframe_sequence_rep_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Keyframe sequence repetition counter
// An accepted item passes the input register and then the output register,
// which offers its result until taken. Throughput: one item per cycle while
// results are taken at once, set by the single compare-and-update stage.
// Reset (synchronous): clears counters, indices, flags and registers; the
// keyframe tables are not cleared and hold no data until loaded.
// ----------------------------------------------------------------------------
module keyframe_sequence_rep_counter_unit (
   input  logic                            clock,
   input  logic                            reset,
   ksrc_req_if.sink                        req_chan,
   ksrc_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ksrc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ksrc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ksrc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Each item enters an input register. While it is there the keyframe
   // tables are read at the current complete and perfect positions, both
   // ternary compares run, the counters move and the result is captured in
   // the output register. The input register empties whenever the output
   // register can take a new result, so while a finished result waits
   // downstream the block takes at most one further item and then stalls.

   ksrc_pkg::cfg_type              cfg;
   ksrc_pkg::req_item_type         req_item;
   ksrc_pkg::rsp_item_type         rsp_item;
   ksrc_pkg::store_wr_type         store_wr;
   ksrc_pkg::keyframe_type         full_rd;
   ksrc_pkg::keyframe_type         ideal_rd;
   logic [ksrc_pkg::INDEX_W-1:0]   full_addr;
   logic [ksrc_pkg::INDEX_W-1:0]   ideal_addr;
   logic                           req_ready;
   logic                           rsp_valid;

   // Request payload gathered into one item.
   assign req_item.func          = req_chan.func;
   assign req_item.frame_slot    = req_chan.frame_slot;
   assign req_item.pattern_codes = req_chan.pattern_codes;
   assign req_item.care_bits     = req_chan.care_bits;
   assign req_item.pose_codes    = req_chan.pose_codes;
   assign req_item.run_enable    = req_chan.run_enable;
   assign req_chan.ready         = req_ready;

   ksrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Loads write the tables at the same edge as the item's result is
   // captured, so a pose sample straight after a load sees the new keyframe.
   ksrc_store u_store (
      .clock      (clock),
      .wr         (store_wr),
      .full_addr  (full_addr),
      .ideal_addr (ideal_addr),
      .full_rd    (full_rd),
      .ideal_rd   (ideal_rd)
   );

   ksrc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_item   (req_item),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_ready  (rsp_chan.ready),
      .cfg        (cfg),
      .store_wr   (store_wr),
      .full_addr  (full_addr),
      .ideal_addr (ideal_addr),
      .full_rd    (full_rd),
      .ideal_rd   (ideal_rd)
   );

   // Result item spread onto the channel.
   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.reps_done        = rsp_item.reps_done;
   assign rsp_chan.seconds_done     = rsp_item.seconds_done;
   assign rsp_chan.last_rep_perfect = rsp_item.last_rep_perfect;
   assign rsp_chan.frame_position   = rsp_item.frame_position;
   assign rsp_chan.rep_event        = rsp_item.rep_event;
   assign rsp_chan.tick_event       = rsp_item.tick_event;
   assign rsp_chan.end_event        = rsp_item.end_event;
   assign rsp_chan.finished         = rsp_item.finished;

endmodule

// ----- src/ksrc_checker.sv -----
// ----------------------------------------------------------------------------
// Keyframe repetition counter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ksrc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ksrc_pkg::COUNT_W-1:0] rsp_reps_done,
   input logic [ksrc_pkg::INDEX_W-1:0] rsp_frame_position,
   input logic                         rsp_rep_event,
   input logic                         rsp_end_event,
   input logic                         rsp_finished
);

   logic [ksrc_pkg::COUNT_W-1:0] last_reps_ff;
   logic                         fin_seen_ff;
   logic                         delivered;

   assign delivered = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_reps_ff <= '0;
         fin_seen_ff  <= 1'b0;
      end else if (delivered) begin
         last_reps_ff <= rsp_reps_done;
         fin_seen_ff  <= fin_seen_ff || rsp_finished;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_reps_monotonic: assert property (@(posedge clock) disable iff (reset)
      delivered |-> rsp_reps_done >= last_reps_ff)
      else $error("repetition count went backwards");

   a_rep_restart: assert property (@(posedge clock) disable iff (reset)
      delivered && rsp_rep_event |-> (rsp_frame_position == '0) && (rsp_reps_done != '0))
      else $error("repetition did not restart the keyframe sequence");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      delivered && (fin_seen_ff || rsp_end_event) |-> rsp_finished)
      else $error("finished flag dropped or missing after a limit");

endmodule

bind keyframe_sequence_rep_counter_unit ksrc_checker u_ksrc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_reps_done      (rsp_chan.reps_done),
   .rsp_frame_position (rsp_chan.frame_position),
   .rsp_rep_event      (rsp_chan.rep_event),
   .rsp_end_event      (rsp_chan.end_event),
   .rsp_finished       (rsp_chan.finished)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Keyframe sequence repetition counter testbench
// Loads the keyframe tables, then runs directed checks of the single-frame and
// multi-frame matching, random traffic under several register settings, and
// the time and count limit cases. Every result is compared field by field
// against a predictor that tracks the counter's state item by item.
// ----------------------------------------------------------------------------
module tb_top;
   import ksrc_pkg::*;

   // Function codes that the block does not define. They must leave the state
   // alone and still report the status.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   localparam int IDLE_PERCENT = 38;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ksrc_req_if req_chan ();
   ksrc_rsp_if rsp_chan ();

   keyframe_sequence_rep_counter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predicted state of the counter. The keyframe tables are filled before the
   // first pose item, so the predictor never looks at an unwritten entry.
   // ------------------------------------------------------------------------
   logic [PATTERN_W-1:0]     full_codes_tbl  [MAX_FRAMES];
   logic [FEATURE_COUNT-1:0] full_care_tbl   [MAX_FRAMES];
   logic [PATTERN_W-1:0]     ideal_codes_tbl [MAX_FRAMES];
   logic [FEATURE_COUNT-1:0] ideal_care_tbl  [MAX_FRAMES];
   int unsigned              full_pos = 0;
   int unsigned              ideal_pos = 0;
   logic [COUNT_W-1:0]       rep_count = '0;
   logic [COUNT_W-1:0]       second_count = '0;
   logic                     perfect_seen = 1'b0;
   logic                     is_running = 1'b0;
   logic                     is_ended = 1'b0;

   // Predicted register contents, as after reset.
   logic [COUNT_W-1:0]       rep_limit_reg = '0;
   logic [COUNT_W-1:0]       second_limit_reg = '0;
   logic [FRAMES_W-1:0]      frames_reg = FRAMES_RESET;

   // Status items still owed by the block, oldest first.
   rsp_item_type             pending_status [$];
   int                       rsp_errors = 0;
   int                       csr_errors = 0;

   // Idling controls: random gaps on both sides, and a counted hold-off of the
   // result channel that lets the block fill up and stall its input. A test
   // asks for a hold-off by setting its length and bumping the request number.
   bit                       idling_on = 1'b1;
   int                       hold_len = 0;
   int                       hold_req = 0;
   int                       hold_ack = 0;
   int                       hold_off_left = 0;

   // The register value 0 counts as one keyframe and anything above the table
   // size counts as the whole table.
   function automatic int unsigned frames_active();
      if (frames_reg == '0) return 1;
      if (frames_reg > MAX_FRAMES) return MAX_FRAMES;
      return frames_reg;
   endfunction

   // Spreads one care bit over the code bits of its feature.
   function automatic logic [PATTERN_W-1:0] care_to_mask(input logic [FEATURE_COUNT-1:0] care);
      logic [PATTERN_W-1:0] mask;
      for (int i = 0; i < FEATURE_COUNT; i++) begin
         mask[i*CODE_BITS +: CODE_BITS] = {CODE_BITS{care[i]}};
      end
      return mask;
   endfunction

   function automatic bit pose_hits(input logic [PATTERN_W-1:0]     codes,
                                    input logic [FEATURE_COUNT-1:0] care,
                                    input logic [PATTERN_W-1:0]     pose);
      return ((codes ^ pose) & care_to_mask(care)) == '0;
   endfunction

   // Reports a differing value and returns 1 for it, else 0.
   function automatic int check_field(input string                 name,
                                      input logic [CSR_DATA_W-1:0] want,
                                      input logic [CSR_DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Applies one accepted item to the predicted state and returns the status
   // that the block must report for it.
   function automatic rsp_item_type predict_status(input req_item_type it);
      rsp_item_type st;
      int unsigned  frames;
      frames = frames_active();
      st = '0;
      case (it.func)
         FUNC_LOAD_FULL: begin
            full_codes_tbl[it.frame_slot] = it.pattern_codes;
            full_care_tbl[it.frame_slot]  = it.care_bits;
         end
         FUNC_LOAD_IDEAL: begin
            ideal_codes_tbl[it.frame_slot] = it.pattern_codes;
            ideal_care_tbl[it.frame_slot]  = it.care_bits;
         end
         FUNC_POSE: begin
            // Poses count whether or not the action is running or has ended.
            if (pose_hits(full_codes_tbl[full_pos], full_care_tbl[full_pos], it.pose_codes)) begin
               full_pos++;
               if (ideal_pos < frames) begin
                  if (pose_hits(ideal_codes_tbl[ideal_pos], ideal_care_tbl[ideal_pos],
                                it.pose_codes)) begin
                     ideal_pos++;
                  end
               end
               if (full_pos >= frames) begin
                  if (rep_count != COUNT_MAX) rep_count++;
                  perfect_seen = (ideal_pos >= frames);
                  st.rep_event = 1'b1;
                  if (rep_limit_reg != '0 && rep_count >= rep_limit_reg) begin
                     is_ended     = 1'b1;
                     st.end_event = 1'b1;
                  end
                  full_pos  = 0;
                  ideal_pos = 0;
               end
            end
         end
         FUNC_TICK: begin
            if (is_running && !is_ended) begin
               if (second_count != COUNT_MAX) second_count++;
               st.tick_event = 1'b1;
               if (second_limit_reg != '0 && second_count >= second_limit_reg) begin
                  is_ended     = 1'b1;
                  st.end_event = 1'b1;
               end
            end
         end
         FUNC_SET_ACTIVE: is_running = it.run_enable;
         FUNC_STOP:       is_ended = 1'b1;
         default: ;
      endcase
      st.reps_done        = rep_count;
      st.seconds_done     = second_count;
      st.last_rep_perfect = perfect_seen;
      st.frame_position   = INDEX_W'(full_pos);
      st.finished         = is_ended;
      return st;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [PATTERN_W-1:0] random_codes();
      return PATTERN_W'({$urandom(), $urandom()});
   endfunction

   // Mostly sparse care masks, so that random poses have a fair chance, with
   // the all-compared and the all-ignored masks now and then.
   function automatic logic [FEATURE_COUNT-1:0] sparse_care();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return '1;
      if (pick < 20) return '0;
      return FEATURE_COUNT'($urandom() & $urandom());
   endfunction

   // Every field is random, so the fields an item does not use see noise.
   function automatic req_item_type random_item();
      req_item_type it;
      it.func          = FUNC_W'($urandom());
      it.frame_slot    = INDEX_W'($urandom());
      it.pattern_codes = random_codes();
      it.care_bits     = FEATURE_COUNT'($urandom());
      it.pose_codes    = random_codes();
      it.run_enable    = 1'($urandom());
      return it;
   endfunction

   // A pose that matches the awaited complete keyframe and, on request, the
   // awaited perfect keyframe too; the remaining features are random.
   function automatic logic [PATTERN_W-1:0] make_pose(input bit hit_full, input bit hit_ideal);
      logic [PATTERN_W-1:0] pose;
      logic [PATTERN_W-1:0] mask;
      pose = random_codes();
      if (hit_ideal && ideal_pos < frames_active()) begin
         mask = care_to_mask(ideal_care_tbl[ideal_pos]);
         pose = (pose & ~mask) | (ideal_codes_tbl[ideal_pos] & mask);
      end
      if (hit_full) begin
         mask = care_to_mask(full_care_tbl[full_pos]);
         pose = (pose & ~mask) | (full_codes_tbl[full_pos] & mask);
      end
      return pose;
   endfunction

   // Offers one item and returns at the falling edge after it was taken. The
   // valid stays high on return, so back-to-back items keep it high.
   task automatic send_item(input req_item_type it);
      rsp_item_type owed;
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.func          <= it.func;
      req_chan.frame_slot    <= it.frame_slot;
      req_chan.pattern_codes <= it.pattern_codes;
      req_chan.care_bits     <= it.care_bits;
      req_chan.pose_codes    <= it.pose_codes;
      req_chan.run_enable    <= it.run_enable;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      owed           = predict_status(it);
      pending_status = {pending_status, owed};
      @(negedge clock);
   endtask

   task automatic send_func(input logic [FUNC_W-1:0] func);
      req_item_type it;
      it      = random_item();
      it.func = func;
      send_item(it);
   endtask

   task automatic send_active(input logic enable);
      req_item_type it;
      it            = random_item();
      it.func       = FUNC_SET_ACTIVE;
      it.run_enable = enable;
      send_item(it);
   endtask

   task automatic send_pose(input logic [PATTERN_W-1:0] pose);
      req_item_type it;
      it            = random_item();
      it.func       = FUNC_POSE;
      it.pose_codes = pose;
      send_item(it);
   endtask

   task automatic load_keyframe(input logic [FUNC_W-1:0]        func,
                                input int                       slot,
                                input logic [PATTERN_W-1:0]     codes,
                                input logic [FEATURE_COUNT-1:0] care);
      req_item_type it;
      it               = random_item();
      it.func          = func;
      it.frame_slot    = INDEX_W'(slot);
      it.pattern_codes = codes;
      it.care_bits     = care;
      send_item(it);
   endtask

   // Lowers valid and waits until every owed status item has come back.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // One register write (setup then access phase) followed by a read back.
   task automatic write_csr(input logic [REG_SEL_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] stored;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      stored = '0;
      case (idx)
         REG_REP_LIMIT: begin
            rep_limit_reg = value[COUNT_W-1:0];
            stored        = CSR_DATA_W'(rep_limit_reg);
         end
         REG_SECOND_LIMIT: begin
            second_limit_reg = value[COUNT_W-1:0];
            stored           = CSR_DATA_W'(second_limit_reg);
         end
         REG_FRAMES_IN_USE: begin
            frames_reg = value[FRAMES_W-1:0];
            stored     = CSR_DATA_W'(frames_reg);
         end
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_errors += check_field("register read back", stored, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Registers are only written with nothing in flight.
   task automatic configure(input logic [CSR_DATA_W-1:0] rep_lim,
                            input logic [CSR_DATA_W-1:0] sec_lim,
                            input logic [CSR_DATA_W-1:0] frames);
      settle();
      write_csr(REG_REP_LIMIT, rep_lim);
      write_csr(REG_SECOND_LIMIT, sec_lim);
      write_csr(REG_FRAMES_IN_USE, frames);
   endtask

   // ------------------------------------------------------------------------
   // Result channel: ready with random gaps, or held low for a counted stretch
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack       <= hold_req;
         hold_off_left  <= hold_len - 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_left  <= hold_off_left - 1;
      end else begin
         rsp_chan.ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Each status item taken is compared with the oldest one owed.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t: status item arrived with none expected", $time);
            rsp_errors++;
         end else begin
            want = pending_status.pop_front();
            rsp_errors += check_field("reps_done", want.reps_done, rsp_chan.reps_done);
            rsp_errors += check_field("seconds_done", want.seconds_done,
                                      rsp_chan.seconds_done);
            rsp_errors += check_field("last_rep_perfect", want.last_rep_perfect,
                                      rsp_chan.last_rep_perfect);
            rsp_errors += check_field("frame_position", want.frame_position,
                                      rsp_chan.frame_position);
            rsp_errors += check_field("rep_event", want.rep_event, rsp_chan.rep_event);
            rsp_errors += check_field("tick_event", want.tick_event, rsp_chan.tick_event);
            rsp_errors += check_field("end_event", want.end_event, rsp_chan.end_event);
            rsp_errors += check_field("finished", want.finished, rsp_chan.finished);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Fills both tables completely. The complete keyframes never compare the
   // last feature, while the perfect keyframes carry the same codes and
   // compare every feature, so flipping the last feature of a matching pose
   // spoils perfection without breaking the match. Slot 0 holds all-ones codes
   // and slot 15 is all zero with nothing compared.
   task automatic test_keyframe_fill();
      logic [PATTERN_W-1:0]     codes;
      logic [FEATURE_COUNT-1:0] care;
      configure(0, 0, 1);
      for (int s = 0; s < MAX_FRAMES; s++) begin
         codes = random_codes();
         care  = sparse_care();
         if (s == 0) begin
            codes = '1;
            care  = 17'h000FF;
         end
         if (s == MAX_FRAMES - 1) begin
            codes = '0;
            care  = '0;
         end
         care[FEATURE_COUNT-1] = 1'b0;
         load_keyframe(FUNC_LOAD_FULL, s, codes, care);
         load_keyframe(FUNC_LOAD_IDEAL, s, codes, '1);
      end
   endtask

   // One keyframe per repetition: pause and resume, ticks, undefined codes,
   // perfect and imperfect repetitions and a pose that does not match.
   task automatic test_single_frame();
      logic [PATTERN_W-1:0] pose;
      send_func(FUNC_TICK);
      send_func(FUNC_UNUSED_LO);
      send_func(FUNC_UNUSED_HI);
      send_active(1'b1);
      send_func(FUNC_TICK);
      send_pose('1);
      pose = '1;
      pose[PATTERN_W-1 -: CODE_BITS] = '0;
      send_pose(pose);
      send_pose('0);
      send_active(1'b0);
      send_func(FUNC_TICK);
      send_active(1'b1);
   endtask

   // Three-keyframe repetitions, one perfect and one spoiled in its middle,
   // then a position left beyond a shrunken frame count.
   task automatic test_frame_sequence();
      logic [PATTERN_W-1:0] pose;
      configure(0, 0, 3);
      repeat (3) send_pose(make_pose(1'b1, 1'b1));
      send_pose(make_pose(1'b1, 1'b1));
      pose = make_pose(1'b1, 1'b1);
      pose[PATTERN_W-1 -: CODE_BITS] = ~pose[PATTERN_W-1 -: CODE_BITS];
      send_pose(pose);
      send_pose(make_pose(1'b1, 1'b1));
      configure(0, 0, 8);
      repeat (5) send_pose(make_pose(1'b1, 1'b1));
      configure(0, 0, 2);
      send_pose(make_pose(1'b1, 1'b1));
   endtask

   // Mostly poses that follow the loaded sequence, mixed with ticks, table
   // reloads, pause and resume, undefined codes and unmatched poses.
   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] frames,
                                   input logic [CSR_DATA_W-1:0] rep_lim,
                                   input logic [CSR_DATA_W-1:0] sec_lim,
                                   input int                    count,
                                   input int                    hold_cycles,
                                   input bit                    allow_stop);
      req_item_type it;
      int           pick;
      configure(rep_lim, sec_lim, frames);
      if (hold_cycles > 0) begin
         hold_len = hold_cycles;
         hold_req++;
      end
      repeat (count) begin
         it   = random_item();
         pick = $urandom_range(99);
         if (pick < 55) begin
            it.func = FUNC_POSE;
            if ($urandom_range(99) < 85) begin
               it.pose_codes = make_pose(1'b1, $urandom_range(99) < 80);
            end
         end else if (pick < 68) begin
            it.func = FUNC_TICK;
         end else if (pick < 76) begin
            it.func      = $urandom_range(1) ? FUNC_LOAD_FULL : FUNC_LOAD_IDEAL;
            it.care_bits = sparse_care();
         end else if (pick < 84) begin
            it.func       = FUNC_SET_ACTIVE;
            it.run_enable = $urandom_range(99) < 75;
         end else if (pick < 90) begin
            it.func = $urandom_range(1) ? FUNC_UNUSED_LO : FUNC_UNUSED_HI;
         end else if (allow_stop && pick < 92) begin
            it.func = FUNC_STOP;
         end else begin
            it.func = FUNC_POSE;
         end
         send_item(it);
      end
   endtask

   // The limits stay out of reach and no stop is sent here, so the action never ends.
   task automatic test_random_traffic();
      run_random_phase(2, 0, 0, 110, 400, 1'b0);
      run_random_phase(4, 40000, 0, 110, 0, 1'b0);
      idling_on = 1'b0;
      run_random_phase(16, 0, 50000, 110, 0, 1'b0);
      idling_on = 1'b1;
      run_random_phase(0, 0, 0, 110, 0, 1'b0);
      run_random_phase(31, 0, 0, 150, 0, 1'b0);
      run_random_phase(3, 40000, 50000, 110, 300, 1'b0);
      run_random_phase(1, 0, 0, 110, 0, 1'b0);
   endtask

   // A time limit a few seconds ahead ends the action; later ticks are
   // ignored and a stop raises no end event.
   task automatic test_second_limit();
      configure(0, CSR_DATA_W'(second_count) + 3, 1);
      idling_on = 1'b0;
      send_active(1'b1);
      repeat (5) send_func(FUNC_TICK);
      send_func(FUNC_STOP);
      idling_on = 1'b1;
   endtask

   // The count limit fires on reaching it and again on every later
   // repetition; then a long keyframe sequence runs with the limit out of reach.
   task automatic test_rep_limit();
      configure(CSR_DATA_W'(rep_count) + 2, 0, 1);
      repeat (4) send_pose(make_pose(1'b1, 1'($urandom_range(1))));
      idling_on = 1'b0;
      configure(1, 0, 1);
      repeat (2) send_pose(make_pose(1'b1, 1'b1));
      repeat (2) send_pose(make_pose(1'b1, 1'b0));
      configure(COUNT_MAX, 0, 16);
      repeat (2 * MAX_FRAMES) send_pose(make_pose(1'b1, 1'b1));
      idling_on = 1'b1;
   endtask

   task automatic test_after_end();
      run_random_phase(5, 1, 1, 150, 0, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.func          = '0;
      req_chan.frame_slot    = '0;
      req_chan.pattern_codes = '0;
      req_chan.care_bits     = '0;
      req_chan.pose_codes    = '0;
      req_chan.run_enable    = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_keyframe_fill();
      test_single_frame();
      test_frame_sequence();
      test_random_traffic();
      test_second_limit();
      test_rep_limit();
      test_after_end();

      // Every item owes exactly one status item; the wait after settling catches
      // any that the block adds on its own.
      settle();
      repeat (4) @(posedge clock);
      if (rsp_errors == 0 && csr_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
